// File: rtl/read_request_frame_builder_unit_macros.svh
// Assertion macros for the read request frame builder.
// Used by the top level; expects a clock named clk and a reset named rst in scope.
`ifndef READ_REQUEST_FRAME_BUILDER_UNIT_MACROS_SVH
`define READ_REQUEST_FRAME_BUILDER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define RRFB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RRFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rrfb_pkg.sv
// Types, constants and the CRC-16 byte update for the read request frame builder.
// No dependencies; used by every module of the block.
package rrfb_pkg;

  localparam int unsigned RLEN_W = 18;
  localparam int unsigned POS_W  = 3;

  localparam logic [7:0]  FN_READ_COILS    = 8'h01;
  localparam logic [7:0]  FN_READ_DISCRETE = 8'h02;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;
  localparam logic [RLEN_W-1:0] RLEN_BASE  = 18'd5;

  // frame byte positions
  localparam logic [POS_W-1:0] POS_SLAVE    = 3'd0;
  localparam logic [POS_W-1:0] POS_FUNC     = 3'd1;
  localparam logic [POS_W-1:0] POS_ADDR_HI  = 3'd2;
  localparam logic [POS_W-1:0] POS_ADDR_LO  = 3'd3;
  localparam logic [POS_W-1:0] POS_COUNT_HI = 3'd4;
  localparam logic [POS_W-1:0] POS_COUNT_LO = 3'd5;
  localparam logic [POS_W-1:0] POS_CRC_LO   = 3'd6;
  localparam logic [POS_W-1:0] POS_CRC_HI   = 3'd7;
  localparam logic [POS_W-1:0] POS_LAST     = POS_CRC_HI;

  typedef struct packed {
    logic [7:0]  slave_id;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] register_count;
  } req_t;

  typedef struct packed {
    logic [7:0]        frame_byte;
    logic [POS_W-1:0]  byte_position;
    logic              last_byte;
    logic [RLEN_W-1:0] response_length;
  } rsp_t;

  // classified request as it travels from front to back
  typedef struct packed {
    req_t              req;
    logic [RLEN_W-1:0] response_length;
  } job_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/rrfb_front.sv
// Front end: accepts poll requests, works out the expected reply length and
// holds the classified item in a register. Depends on rrfb_pkg.
module rrfb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  rrfb_pkg::req_t    req,
  output logic              job_valid,
  input  logic              job_ready,
  output rrfb_pkg::job_t    job
);
  import rrfb_pkg::*;

  logic              is_bit_read;
  logic [RLEN_W-1:0] bit_len;
  logic [RLEN_W-1:0] reg_len;
  logic [RLEN_W-1:0] rlen;
  logic              take;

  always_comb begin
    is_bit_read = (req.function_code == FN_READ_COILS) ||
                  (req.function_code == FN_READ_DISCRETE);
    // bytes of packed bits, rounded up, plus header and CRC
    bit_len = {5'd0, req.register_count[15:3]} + RLEN_BASE +
              {{(RLEN_W-1){1'b0}}, |req.register_count[2:0]};
    reg_len = {1'b0, req.register_count, 1'b0} + RLEN_BASE;
    rlen    = is_bit_read ? bit_len : reg_len;
  end

  assign req_ready = !job_valid || job_ready;
  assign take      = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (req_ready) begin
      job_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job.req             <= req;
      job.response_length <= rlen;
    end
  end

endmodule

// File: rtl/rrfb_queue.sv
// Small register FIFO decoupling the front end from the byte sequencer.
// Depends on rrfb_pkg for the item type.
module rrfb_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rrfb_pkg::job_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rrfb_pkg::job_t out_data
);
  import rrfb_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_FULL);
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

// File: rtl/rrfb_back.sv
// Back end: walks one request through its eight frame bytes, one per cycle while
// not stalled, folding each header byte into the running CRC. Depends on rrfb_pkg.
module rrfb_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_ready,
  input  rrfb_pkg::job_t job,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output rrfb_pkg::rsp_t rsp
);
  import rrfb_pkg::*;

  logic             busy;
  logic [POS_W-1:0] pos;
  job_t             cur;
  logic [15:0]      crc;
  logic [15:0]      crc_next;
  logic [7:0]       byte_sel;
  logic             fire;
  logic             emit;
  logic             pop;
  logic             at_last;

  assign fire      = !rsp_valid || rsp_ready;
  assign emit      = busy && fire;
  assign at_last   = (pos == POS_LAST);
  // next item loads on the cycle the final byte leaves, so frames run back to back
  assign job_ready = !busy || (emit && at_last);
  assign pop       = job_valid && job_ready;

  always_comb begin
    case (pos)
      POS_SLAVE:    byte_sel = cur.req.slave_id;
      POS_FUNC:     byte_sel = cur.req.function_code;
      POS_ADDR_HI:  byte_sel = cur.req.start_address[15:8];
      POS_ADDR_LO:  byte_sel = cur.req.start_address[7:0];
      POS_COUNT_HI: byte_sel = cur.req.register_count[15:8];
      POS_COUNT_LO: byte_sel = cur.req.register_count[7:0];
      POS_CRC_LO:   byte_sel = crc[7:0];
      POS_CRC_HI:   byte_sel = crc[15:8];
      default:      byte_sel = 8'h00;
    endcase
    crc_next = crc16_byte(crc, byte_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pos       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (fire) begin
        rsp_valid <= busy;
      end
      if (emit) begin
        pos <= pos + 1'b1;
        if (at_last) begin
          busy <= 1'b0;
        end
      end
      if (pop) begin
        busy <= 1'b1;
        pos  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.frame_byte      <= byte_sel;
      rsp.byte_position   <= pos;
      rsp.last_byte       <= at_last;
      rsp.response_length <= cur.response_length;
      if (pos < POS_CRC_LO) begin
        crc <= crc_next;
      end
    end
    if (pop) begin
      cur <= job;
      crc <= CRC_INIT;
    end
  end

endmodule

// File: rtl/read_request_frame_builder_unit.sv
// Read request frame builder: turns a poll request into an eight-byte
// read request frame with CRC-16 (init 0xFFFF, reflected poly 0xA001).
//
// Channels: req (valid/ready, one request per item) and rsp (valid/ready,
// one frame byte per item, tagged with its position, a last flag on the
// high CRC byte, and the expected reply length).
// Byte order: slave, function, address hi/lo, count hi/lo, CRC lo, CRC hi.
// Path: an accepted request passes through the front register and the queue
// into the sequencer, whose output register holds each frame byte in turn.
// Throughput: the byte sequencer emits one byte per cycle while the receiver
// keeps up. Requests are taken every cycle until the front register
// and the QUEUE_DEPTH-entry queue are full.
// Reset: empties the front register, queue and sequencer; no frame is
// in flight afterwards.
// Receiver stall: the output byte holds until taken; the sequencer pauses,
// and the queue and front register fill before req_ready drops.
// Depends on rrfb_pkg, rrfb_front, rrfb_queue, rrfb_back.
`include "read_request_frame_builder_unit_macros.svh"

module read_request_frame_builder_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  rrfb_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output rrfb_pkg::rsp_t rsp
);
  import rrfb_pkg::*;

  logic fq_valid;
  logic fq_ready;
  job_t fq_job;
  logic qb_valid;
  logic qb_ready;
  job_t qb_job;
  logic rsp_take;

  rrfb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  rrfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_job),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_job)
  );

  rrfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  assign rsp_take = rsp_valid && rsp_ready;

  `RRFB_ASSERT_IMPL(a_last_at_end, rsp_valid && rsp.last_byte, rsp.byte_position == POS_LAST, "last flag off the final byte")
  `RRFB_ASSERT_NEXT(a_frame_steps, rsp_take && !rsp.last_byte, rsp_valid && (rsp.byte_position == $past(rsp.byte_position) + 3'd1), "frame bytes not consecutive")
  `RRFB_ASSERT_NEXT(a_len_steady, rsp_take && !rsp.last_byte, rsp.response_length == $past(rsp.response_length), "reply length changed inside a frame")

endmodule
